FILE: src/gdrp_pkg.sv
// Shared types and constants for the grey depth reducer packer.
package gdrp_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int MODE_W      = 3;
    localparam int SLOT_W      = 3;
    localparam int PPB_W       = 4;
    localparam int SUM_W       = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_PACK_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'd1;

    localparam logic [MODE_W-1:0] MODE_THRESH  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DITHER1 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GREY2   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GREY4   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DITHER2 = 3'd4;

    localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd127;
    localparam logic [PIXEL_W-1:0] MONO_BIT        = 8'h80;
    localparam logic [PIXEL_W-1:0] GREY2_MASK      = 8'hC0;
    localparam logic [PIXEL_W-1:0] GREY4_MASK      = 8'hF0;
    localparam logic [SUM_W-1:0]   DITHER2_MASK    = 9'h180;

    localparam logic [PPB_W-1:0] PPB_MONO = 4'd8;
    localparam logic [PPB_W-1:0] PPB_GREY2 = 4'd4;
    localparam logic [PPB_W-1:0] PPB_GREY4 = 4'd2;

    typedef enum logic [2:0] {
        OP_THRESH,
        OP_DITHER1,
        OP_GREY2,
        OP_GREY4,
        OP_DITHER2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              thr_bit;
        logic [PPB_W-1:0]  per_byte;
        logic [PIXEL_W-1:0] pixel;
        logic              last;
    } item_t;

endpackage

FILE: src/gdrp_front.sv
// Front end: configuration registers and per-pixel classification.
module gdrp_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [gdrp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gdrp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [gdrp_pkg::PIXEL_W-1:0]     pixel,
    input  logic                            last_pixel,
    output gdrp_pkg::item_t                 item
);
    import gdrp_pkg::*;

    logic [MODE_W-1:0]  pack_mode_reg;
    logic [PIXEL_W-1:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_mode_reg <= MODE_THRESH;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PACK_MODE: pack_mode_reg <= cfg_data[MODE_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[PIXEL_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        item.pixel   = pixel;
        item.last    = last_pixel;
        item.thr_bit = pixel > threshold_reg;
        unique case (pack_mode_reg)
            MODE_DITHER1:
            begin
                item.op       = OP_DITHER1;
                item.per_byte = PPB_MONO;
            end
            MODE_GREY2:
            begin
                item.op       = OP_GREY2;
                item.per_byte = PPB_GREY2;
            end
            MODE_GREY4:
            begin
                item.op       = OP_GREY4;
                item.per_byte = PPB_GREY4;
            end
            MODE_DITHER2:
            begin
                item.op       = OP_DITHER2;
                item.per_byte = PPB_GREY2;
            end
            default:
            begin
                item.op       = OP_THRESH;
                item.per_byte = PPB_MONO;
            end
        endcase
    end

endmodule

FILE: src/gdrp_queue.sv
// Short queue of classified pixels between the front and back ends.
module gdrp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gdrp_pkg::item_t push_item,
    input  logic            pop,
    output gdrp_pkg::item_t head_item,
    output logic            full,
    output logic            empty
);
    import gdrp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/gdrp_back.sv
// Back end: dither sum, byte accumulation and the output register.
module gdrp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gdrp_pkg::item_t             head_item,
    input  logic                        empty,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [gdrp_pkg::PIXEL_W-1:0] packed_byte,
    output logic                        last_byte
);
    import gdrp_pkg::*;

    logic [PIXEL_W-1:0] acc_reg, acc_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] packed_byte_reg, packed_byte_next;
    logic               last_byte_reg, last_byte_next;

    logic [SUM_W-1:0]   sum_add;
    logic [SUM_W-1:0]   sum_new;
    logic [SUM_W-1:0]   grey_bits;
    logic [PIXEL_W-1:0] contrib;
    logic [PIXEL_W-1:0] filled;
    logic [PPB_W-1:0]   slot_p1;
    logic               emit;

    assign pop = !empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        sum_add   = sum_reg + {1'b0, head_item.pixel};
        sum_new   = sum_reg;
        grey_bits = '0;
        contrib   = '0;
        unique case (head_item.op)
            OP_DITHER1:
            begin
                sum_new = sum_add;
                if (sum_add[SUM_W-1])
                begin
                    sum_new = {1'b0, sum_add[SUM_W-2:0]};
                    contrib = MONO_BIT >> slot_reg;
                end
            end
            OP_GREY2:
            begin
                contrib = (head_item.pixel & GREY2_MASK) >> {slot_reg, 1'b0};
            end
            OP_GREY4:
            begin
                contrib = (head_item.pixel & GREY4_MASK) >> {slot_reg, 2'b00};
            end
            OP_DITHER2:
            begin
                grey_bits = sum_add & DITHER2_MASK;
                sum_new   = sum_add & ~DITHER2_MASK;
                contrib   = PIXEL_W'(grey_bits >> {slot_reg, 1'b1});
            end
            OP_THRESH:
            begin
                contrib = head_item.thr_bit ? (MONO_BIT >> slot_reg) : '0;
            end
            default:
            begin
                contrib = '0;
            end
        endcase
        filled  = acc_reg | contrib;
        slot_p1 = {1'b0, slot_reg} + 1'b1;
        emit    = head_item.last || (slot_p1 >= head_item.per_byte);
    end

    always_comb
    begin
        acc_next         = acc_reg;
        slot_next        = slot_reg;
        sum_next         = sum_reg;
        out_valid_next   = out_valid_reg && out_stall;
        packed_byte_next = packed_byte_reg;
        last_byte_next   = last_byte_reg;
        if (pop)
        begin
            acc_next  = emit ? '0 : filled;
            slot_next = emit ? '0 : slot_p1[SLOT_W-1:0];
            sum_next  = head_item.last ? '0 : sum_new;
            if (emit)
            begin
                out_valid_next   = 1'b1;
                packed_byte_next = filled;
                last_byte_next   = head_item.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            slot_reg      <= slot_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        packed_byte_reg <= packed_byte_next;
        last_byte_reg   <= last_byte_next;
    end

    assign out_valid   = out_valid_reg;
    assign packed_byte = packed_byte_reg;
    assign last_byte   = last_byte_reg;

endmodule

FILE: src/grey_depth_reducer_packer.sv
// Grey pixel depth reducer and byte packer, top level.
// Takes one 8-bit grey pixel per clock and packs 1-, 2- or 4-bit reduced
// pixels into bytes, first pixel in the most significant bits. A pixel is
// taken every cycle as long as the output side keeps up; a byte is offered
// from the output register once the pixel completing it has passed through
// the queue. The front end classifies each pixel against the current mode
// and threshold, and a queue of QUEUE_DEPTH entries feeds the back end,
// whose accumulator and dither update sustain one pixel per cycle while the
// output is not stalled. The input stalls only when that queue is full.
// Change pack_mode or threshold only while no transaction is in flight.
module grey_depth_reducer_packer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gdrp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gdrp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [gdrp_pkg::PIXEL_W-1:0]     pixel,
    input  logic                             last_pixel,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [gdrp_pkg::PIXEL_W-1:0]     packed_byte,
    output logic                             last_byte
);
    import gdrp_pkg::*;

    item_t in_item;
    item_t head_item;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    assign in_stall = full;
    assign push     = in_valid && !full;

    gdrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (pixel),
        .last_pixel (last_pixel),
        .item       (in_item)
    );

    gdrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (in_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (full),
        .empty     (empty)
    );

    gdrp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_item   (head_item),
        .empty       (empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packed_byte (packed_byte),
        .last_byte   (last_byte)
    );

endmodule

FILE: src/gdrp_checker.sv
// Port-level assertions for the grey depth reducer packer and their binding.
module gdrp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [gdrp_pkg::PIXEL_W-1:0]     packed_byte,
    input logic                             last_byte
);

    // A stalled output transaction stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    // A stalled output transaction keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(packed_byte) && $stable(last_byte))
        else $error("output payload changed while stalled");

    // No byte is offered in the first cycle after reset.
    a_reset_quiet: assert property (@(posedge clk)
        $past(!rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // With no byte waiting, the queue drains, so the input is never stalled.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output is idle");

endmodule

bind grey_depth_reducer_packer gdrp_checker u_gdrp_checker (.*);

FILE: sim/grey_depth_reducer_packer_tb.sv
// Self-checking testbench for the grey depth reducer packer with a built-in predictor.
`timescale 1ns / 100ps

module grey_depth_reducer_packer_tb;
    import gdrp_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PIXELS = 700;

    typedef struct packed {
        logic [PIXEL_W-1:0] data;
        logic               last;
    } packed_out_t;

    class pack_scoreboard;
        logic [MODE_W-1:0]  mode;
        logic [PIXEL_W-1:0] thr;
        logic [PIXEL_W-1:0] acc;
        logic [SLOT_W-1:0]  slot;
        logic [SUM_W-1:0]   dsum;
        packed_out_t        byte_q[$];
        int                 errors;

        function new();
            mode   = MODE_THRESH;
            thr    = THRESHOLD_RESET;
            acc    = '0;
            slot   = '0;
            dsum   = '0;
            errors = 0;
        endfunction

        function int pending();
            return byte_q.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_PACK_MODE)
                mode = data[MODE_W-1:0];
            else if (idx == REG_THRESHOLD)
                thr = data;
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] px, logic last);
            logic [31:0]      bits;
            logic [SUM_W-1:0] top;
            int               sl;
            int               per;
            packed_out_t      res;
            bits = '0;
            sl   = slot;
            case (mode)
                MODE_DITHER1:
                begin
                    dsum = dsum + px;
                    if (dsum[SUM_W-1])
                    begin
                        dsum[SUM_W-1] = 1'b0;
                        bits = {24'd0, MONO_BIT} >> sl;
                    end
                    per = PPB_MONO;
                end
                MODE_GREY2:
                begin
                    bits = {24'd0, px & GREY2_MASK} >> (2 * sl);
                    per  = PPB_GREY2;
                end
                MODE_GREY4:
                begin
                    bits = {24'd0, px & GREY4_MASK} >> (4 * sl);
                    per  = PPB_GREY4;
                end
                MODE_DITHER2:
                begin
                    dsum = dsum + px;
                    top  = dsum & DITHER2_MASK;
                    dsum = dsum - top;
                    bits = {23'd0, top} >> (1 + 2 * sl);
                    per  = PPB_GREY2;
                end
                default:
                begin
                    if (px > thr)
                        bits = {24'd0, MONO_BIT} >> sl;
                    per = PPB_MONO;
                end
            endcase
            acc = acc | bits[7:0];
            if (last)
            begin
                res.data = acc;
                res.last = 1'b1;
                byte_q.push_back(res);
                acc  = '0;
                slot = '0;
                dsum = '0;
            end
            else if (sl + 1 >= per)
            begin
                res.data = acc;
                res.last = 1'b0;
                byte_q.push_back(res);
                acc  = '0;
                slot = '0;
            end
            else
                slot = SLOT_W'(sl + 1);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_byte(logic [PIXEL_W-1:0] data, logic last);
            packed_out_t want;
            if (byte_q.size() == 0)
                report($sformatf("unexpected byte %02h last %0b", data, last));
            else
            begin
                want = byte_q.pop_front();
                if (data !== want.data)
                    report($sformatf("packed_byte %02h, want %02h", data, want.data));
                if (last !== want.last)
                    report($sformatf("last_byte %0b, want %0b", last, want.last));
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [PIXEL_W-1:0]     pixel;
    logic                   last_pixel;
    logic                   out_valid;
    logic                   out_stall;
    logic [PIXEL_W-1:0]     packed_byte;
    logic                   last_byte;

    pack_scoreboard sb = new();
    bit             tx_quiet;
    bit             rx_quiet;
    int             cycle_count = 0;

    grey_depth_reducer_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .last_pixel  (last_pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packed_byte (packed_byte),
        .last_byte   (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_byte(packed_byte, last_byte);
                stall_left = rx_quiet ? 0 : $urandom_range(0, 7);
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pixel      <= px;
        last_pixel <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pixel(px, last);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    initial
    begin
        int                    sent;
        int                    len;
        int                    hold_at;
        int                    sel;
        logic [CFG_DATA_W-1:0] d;
        logic [PIXEL_W-1:0]    px;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        pixel      <= '0;
        last_pixel <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(8'd127, 1'b0); send_pixel(8'd128, 1'b0);
        send_pixel(8'd0, 1'b0);   send_pixel(8'd255, 1'b1);
        write_reg(REG_THRESHOLD, 8'd255);
        send_pixel(8'd255, 1'b0); send_pixel(8'd254, 1'b1);
        write_reg(REG_PACK_MODE, {5'd0, MODE_DITHER1});
        send_pixel(8'd255, 1'b0); send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0); send_pixel(8'd128, 1'b0);
        send_pixel(8'd255, 1'b0); send_pixel(8'd1, 1'b0);
        send_pixel(8'd255, 1'b0); send_pixel(8'd254, 1'b0);
        write_reg(REG_PACK_MODE, {5'd0, MODE_GREY2});
        send_pixel(8'hC0, 1'b0);  send_pixel(8'h40, 1'b0);  send_pixel(8'hFF, 1'b0);
        // A grey4 pixel landing in a byte that already holds three slots drops off the end.
        write_reg(REG_PACK_MODE, {5'd0, MODE_GREY4});
        send_pixel(8'hF0, 1'b1);
        write_reg(REG_PACK_MODE, {5'd0, MODE_DITHER2});
        send_pixel(8'd255, 1'b0); send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0); send_pixel(8'd128, 1'b1);
        // Reserved mode codes fall back to threshold mono.
        write_reg(REG_PACK_MODE, 8'hFD);
        write_reg(REG_THRESHOLD, 8'd0);
        send_pixel(8'd0, 1'b0);   send_pixel(8'd1, 1'b1);

        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            sel = $urandom_range(0, 11);
            d   = CFG_DATA_W'($urandom());
            if (sel < 10)
                d[MODE_W-1:0] = MODE_W'(sel % 5);
            else
                d[MODE_W-1:0] = MODE_W'($urandom_range(5, 7));
            write_reg(REG_PACK_MODE, d);
            if ($urandom_range(0, 1) == 0)
            begin
                sel = $urandom_range(0, 3);
                d   = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom());
                write_reg(REG_THRESHOLD, d);
            end
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            len      = $urandom_range(20, 80);
            hold_at  = $urandom_range(0, len - 1);
            for (int k = 0; k < len; k++)
            begin
                if (k == hold_at)
                    wait_drained();
                sel = $urandom_range(0, 7);
                px  = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom());
                send_pixel(px, $urandom_range(0, 15) == 0);
                sent++;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: sim.f
src/gdrp_pkg.sv
src/gdrp_front.sv
src/gdrp_queue.sv
src/gdrp_back.sv
src/grey_depth_reducer_packer.sv
src/gdrp_checker.sv
sim/grey_depth_reducer_packer_tb.sv
